// ===== hw/rtl/sjis_text_to_glyph_address_defines.svh =====
// assertion macros used by the shift-jis glyph address top level
`ifndef SJIS_TEXT_TO_GLYPH_ADDRESS_DEFINES_SVH
`define SJIS_TEXT_TO_GLYPH_ADDRESS_DEFINES_SVH

// same-cycle implication, checked on every clock once reset is released
`define SJIS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SJIS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/sjis_pkg.sv =====
// shared types, constants and code range table for the shift-jis glyph address block
`default_nettype none

package sjis_pkg;

    localparam int ByteW           = 8;
    localparam int PenW            = 12;
    localparam int CodeW           = 16;
    localparam int AddrW           = 17;
    localparam int IdxW            = 13;
    localparam int ApbAddrW        = 3;
    localparam int ApbDataW        = 32;
    localparam int CharWidthDefault = 8;
    localparam int RangeCount      = 51;

    localparam logic [PenW-1:0]  PenMax     = '1;
    localparam logic [AddrW-1:0] HalfBase   = 17'd104670;
    localparam logic [ByteW-1:0] FirstGlyph = 8'h21;
    localparam logic [ByteW-1:0] LeadLoA    = 8'h81;
    localparam logic [ByteW-1:0] LeadHiA    = 8'h9f;
    localparam logic [ByteW-1:0] LeadLoB    = 8'he0;

    // register index of font_loaded
    localparam logic RegFontLoaded = 1'b0;

    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_HALF = 2'd1,
        KIND_FULL = 2'd2,
        KIND_END  = 2'd3
    } t_kind;

    typedef logic [CodeW-1:0] t_code_arr [RangeCount];

    typedef struct packed {
        logic             hit;
        logic [AddrW-1:0] addr;
    } t_full_lookup;

    localparam t_code_arr RangeLo = '{
        16'h8140, 16'h8180, 16'h81b8, 16'h81c8, 16'h81da, 16'h81f0, 16'h81fc, 16'h824f,
        16'h8260, 16'h8281, 16'h829f, 16'h8340, 16'h8380, 16'h839f, 16'h83bf, 16'h8440,
        16'h8470, 16'h8480, 16'h849f, 16'h889f, 16'h8940, 16'h8980, 16'h8a40, 16'h8a80,
        16'h8b40, 16'h8b80, 16'h8c40, 16'h8c80, 16'h8d40, 16'h8d80, 16'h8e40, 16'h8e80,
        16'h8f40, 16'h8f80, 16'h9040, 16'h9080, 16'h9140, 16'h9180, 16'h9240, 16'h9280,
        16'h9340, 16'h9380, 16'h9440, 16'h9480, 16'h9540, 16'h9580, 16'h9640, 16'h9680,
        16'h9740, 16'h9780, 16'h9840
    };

    localparam t_code_arr RangeHi = '{
        16'h817e, 16'h81ac, 16'h81bf, 16'h81ce, 16'h81e8, 16'h81f7, 16'h81fc, 16'h8258,
        16'h8279, 16'h829a, 16'h82f1, 16'h837e, 16'h8396, 16'h83b6, 16'h83d6, 16'h8460,
        16'h847e, 16'h8491, 16'h84be, 16'h88fc, 16'h897e, 16'h89fc, 16'h8a7e, 16'h8afc,
        16'h8b7e, 16'h8bfc, 16'h8c7e, 16'h8cfc, 16'h8d7e, 16'h8dfc, 16'h8e7e, 16'h8efc,
        16'h8f7e, 16'h8ffc, 16'h907e, 16'h90fc, 16'h917e, 16'h91fc, 16'h927e, 16'h92fc,
        16'h937e, 16'h93fc, 16'h947e, 16'h94fc, 16'h957e, 16'h95fc, 16'h967e, 16'h96fc,
        16'h977e, 16'h97fc, 16'h9872
    };

    // per range: (codes in earlier ranges - range low), modulo 2^16
    function automatic t_code_arr calc_offsets();
        t_code_arr        offs;
        logic [CodeW-1:0] seen_codes;
        seen_codes = '0;
        for (int r = 0; r < RangeCount; r++) begin
            offs[r]    = seen_codes - RangeLo[r];
            seen_codes = seen_codes + (RangeHi[r] - RangeLo[r]) + 16'd1;
        end
        return offs;
    endfunction

    localparam t_code_arr RangeOffset = calc_offsets();

endpackage

`default_nettype wire

// ===== hw/rtl/sjis_full_lookup.sv =====
// double-byte code to full-width glyph rom address
`default_nettype none

module sjis_full_lookup (
    input  logic [sjis_pkg::CodeW-1:0] i_code,
    output sjis_pkg::t_full_lookup     o_lookup
);
    import sjis_pkg::*;

    logic [RangeCount-1:0] w_hit;
    logic [CodeW-1:0]      w_offset;
    logic [CodeW-1:0]      w_sum;
    logic [IdxW-1:0]       w_idx;
    logic [AddrW:0]        w_addr;

    // ranges are disjoint, so at most one hit and the offsets can be or-ed
    always_comb begin
        w_offset = '0;
        for (int r = 0; r < RangeCount; r++) begin
            w_hit[r] = (i_code >= RangeLo[r]) && (i_code <= RangeHi[r]);
            if (w_hit[r]) begin
                w_offset = w_offset | RangeOffset[r];
            end
        end
    end

    assign w_sum  = i_code + w_offset;
    assign w_idx  = w_sum[IdxW-1:0];
    // index * 30 as index * 32 - index * 2
    assign w_addr = {w_idx, 5'b0} - {4'b0, w_idx, 1'b0};

    assign o_lookup.hit  = |w_hit;
    assign o_lookup.addr = w_addr[AddrW-1:0];

endmodule

`default_nettype wire

// ===== hw/rtl/sjis_text_to_glyph_address.sv =====
// top level: shift-jis byte stream to glyph rom address and pen position
//
// channel    dir  handshake                 payload
// --------   ---  ------------------------  -----------------------------------------
// text in    in   i_in_valid / o_in_ready   i_text_byte, i_string_start, i_start_x,
//                                           i_render_half
// result     out  o_out_valid / i_out_ready o_result_kind, o_font_address, o_char_x
// config     in   apb psel/penable/pready   paddr, pwdata, prdata (font_loaded)
//
// one byte is taken every cycle while o_in_ready is high; each byte is registered in the
// decode stage, then looked up in the table lookup stage and registered as the result
// a lead byte produces no result transaction, every other byte produces one
// the lead/pen state updates at the input transaction, so bytes stream back to back
// a stalled result holds the lookup stage; input stalls only when both stages are full
// synchronous active-low reset clears the pen, the pending lead and font_loaded
`default_nettype none
`include "sjis_text_to_glyph_address_defines.svh"

module sjis_text_to_glyph_address #(
    parameter int CHAR_WIDTH = sjis_pkg::CharWidthDefault
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // text byte transaction
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [sjis_pkg::ByteW-1:0]    i_text_byte,
    input  logic                          i_string_start,
    input  logic [sjis_pkg::PenW-1:0]     i_start_x,
    input  logic                          i_render_half,
    // result transaction
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [1:0]                    o_result_kind,
    output logic [sjis_pkg::AddrW-1:0]    o_font_address,
    output logic [sjis_pkg::PenW-1:0]     o_char_x,
    // register port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sjis_pkg::ApbAddrW-1:0] paddr,
    input  logic [sjis_pkg::ApbDataW-1:0] pwdata,
    output logic [sjis_pkg::ApbDataW-1:0] prdata,
    output logic                          pready
);
    import sjis_pkg::*;

    // pen steps; sum is one bit wider than the pen so overflow is visible
    localparam logic [PenW:0] StepHalf = (PenW+1)'(CHAR_WIDTH);
    localparam logic [PenW:0] StepFull = (PenW+1)'(2 * CHAR_WIDTH);

    // ---------------- register port ----------------
    logic r_font_loaded;
    logic w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_font_loaded <= 1'b0;
        end else if (w_cfg_wr && (paddr[ApbAddrW-1] == RegFontLoaded)) begin
            r_font_loaded <= pwdata[0];
        end
    end

    // only one register, at the addresses with the top bit clear; the rest read as zero
    always_comb begin
        prdata = '0;
        if (paddr[ApbAddrW-1] == RegFontLoaded) begin
            prdata[0] = r_font_loaded;
        end
    end

    // ---------------- handshake and stage enables ----------------
    logic r_s1_valid;
    logic r_out_valid;
    logic w_out_load;   // result register may take the lookup stage
    logic w_s1_load;    // decode register may take a new byte
    logic w_in_fire;

    assign w_out_load = !r_out_valid || i_out_ready;
    assign w_s1_load  = !r_s1_valid || w_out_load;
    assign w_in_fire  = i_in_valid && w_s1_load;
    assign o_in_ready = w_s1_load;

    // ---------------- decode at the input transaction ----------------
    logic              r_lead_pending;
    logic [ByteW-1:0]  r_lead_byte;
    logic [PenW-1:0]   r_pen_x;

    logic              w_cur_pend;
    logic [PenW-1:0]   w_cur_pen;
    logic              w_is_lead;
    logic              w_has_result;
    logic              w_store_lead;
    t_kind             w_kind;
    logic [PenW:0]     w_step;
    logic [PenW:0]     w_pen_sum;
    logic [PenW-1:0]   n_pen_x;

    // string start loads the pen and drops a pending lead before the byte is handled
    assign w_cur_pend = i_string_start ? 1'b0 : r_lead_pending;
    assign w_cur_pen  = i_string_start ? i_start_x : r_pen_x;
    assign w_is_lead  = ((i_text_byte >= LeadLoA) && (i_text_byte <= LeadHiA))
                        || (i_text_byte >= LeadLoB);

    always_comb begin
        w_has_result = 1'b1;
        w_store_lead = 1'b0;
        w_kind       = KIND_NONE;
        w_step       = '0;
        priority if (i_text_byte == '0) begin
            // terminator: report the pen, keep it
            w_kind = KIND_END;
        end else if (w_cur_pend) begin
            // trail byte, any nonzero value completes the pair
            w_kind = KIND_FULL;
            w_step = StepFull;
        end else if (w_is_lead) begin
            w_has_result = 1'b0;
            w_store_lead = 1'b1;
        end else begin
            w_kind = KIND_HALF;
            w_step = StepHalf;
        end
    end

    // saturating pen advance
    assign w_pen_sum = {1'b0, w_cur_pen} + w_step;
    assign n_pen_x   = w_pen_sum[PenW] ? PenMax : w_pen_sum[PenW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lead_pending <= 1'b0;
            r_pen_x        <= '0;
        end else if (w_in_fire) begin
            r_lead_pending <= w_store_lead;
            r_pen_x        <= n_pen_x;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire && w_store_lead) begin
            r_lead_byte <= i_text_byte;
        end
    end

    // decode stage register
    t_kind             r_s1_kind;
    logic [CodeW-1:0]  r_s1_code;   // full code, or byte in the low half
    logic              r_s1_draw;   // half-width glyph allowed by the stream
    logic [PenW-1:0]   r_s1_x;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_s1_load) begin
            r_s1_valid <= w_in_fire && w_has_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_s1_kind <= w_kind;
            r_s1_code <= {(w_cur_pend ? r_lead_byte : {ByteW{1'b0}}), i_text_byte};
            r_s1_draw <= i_render_half && (i_text_byte >= FirstGlyph);
            r_s1_x    <= w_cur_pen;
        end
    end

    // ---------------- lookup stage ----------------
    t_full_lookup      w_full;
    t_kind             w_out_kind;
    logic [AddrW-1:0]  w_out_addr;
    logic [ByteW-1:0]  w_half_ofs;
    logic [AddrW-1:0]  w_half_mul;

    sjis_full_lookup u_full_lookup (
        .i_code   (r_s1_code),
        .o_lookup (w_full)
    );

    // half-width glyph: base + (c - 0x21) * 15, times 15 as times 16 minus one
    assign w_half_ofs = r_s1_code[ByteW-1:0] - FirstGlyph;
    assign w_half_mul = {5'b0, w_half_ofs, 4'b0} - {9'b0, w_half_ofs};

    always_comb begin
        w_out_kind = KIND_NONE;
        w_out_addr = '0;
        unique case (r_s1_kind)
            KIND_END: begin
                w_out_kind = KIND_END;
            end
            KIND_FULL: begin
                if (w_full.hit && r_font_loaded) begin
                    w_out_kind = KIND_FULL;
                    w_out_addr = w_full.addr;
                end
            end
            KIND_HALF: begin
                if (r_s1_draw && r_font_loaded) begin
                    w_out_kind = KIND_HALF;
                    w_out_addr = HalfBase + w_half_mul;
                end
            end
            default: begin
                w_out_kind = KIND_NONE;
            end
        endcase
    end

    // result register
    t_kind             r_out_kind;
    logic [AddrW-1:0]  r_out_addr;
    logic [PenW-1:0]   r_out_x;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load && r_s1_valid) begin
            r_out_kind <= w_out_kind;
            r_out_addr <= w_out_addr;
            r_out_x    <= r_s1_x;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_result_kind  = r_out_kind;
    assign o_font_address = r_out_addr;
    assign o_char_x       = r_out_x;

    // ---------------- checks ----------------
    `SJIS_ASSERT_NOW(a_no_glyph_zero_addr,
        r_out_valid && ((r_out_kind == KIND_NONE) || (r_out_kind == KIND_END)),
        r_out_addr == '0, "non-glyph result carries a nonzero address")
    `SJIS_ASSERT_NOW(a_no_font_no_glyph,
        r_out_valid && !r_font_loaded,
        (r_out_kind != KIND_HALF) && (r_out_kind != KIND_FULL),
        "glyph produced while font not loaded")
    `SJIS_ASSERT_NEXT(a_lead_held,
        w_in_fire && w_store_lead,
        r_lead_pending && (r_lead_byte == $past(i_text_byte)),
        "lead byte not held after transaction")
    `SJIS_ASSERT_NEXT(a_pen_monotonic,
        w_in_fire && !i_string_start,
        r_pen_x >= $past(r_pen_x), "pen moved backward without string start")

endmodule

`default_nettype wire

// ===== tb/sjis_glyph_checker.sv =====
// glyph checker: predicts each result transaction of the shift-jis block and compares it
`timescale 1ns / 1ps

module sjis_glyph_checker #(
    parameter int CharW = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_ready,
    input  logic [sjis_pkg::ByteW-1:0]    i_text_byte,
    input  logic                          i_string_start,
    input  logic [sjis_pkg::PenW-1:0]     i_start_x,
    input  logic                          i_render_half,
    input  logic                          i_out_valid,
    input  logic                          i_out_ready,
    input  logic [1:0]                    i_result_kind,
    input  logic [sjis_pkg::AddrW-1:0]    i_font_address,
    input  logic [sjis_pkg::PenW-1:0]     i_char_x,
    input  logic                          i_psel,
    input  logic                          i_penable,
    input  logic                          i_pwrite,
    input  logic                          i_pready,
    input  logic [sjis_pkg::ApbAddrW-1:0] i_paddr,
    input  logic [sjis_pkg::ApbDataW-1:0] i_pwdata,
    output int                            o_mismatches,
    output int                            o_pending
);

    import sjis_pkg::*;

    localparam int RangeN = 51;
    localparam int PenTop = 4095;
    localparam int FullStep = 30;
    localparam int HalfStep = 15;
    localparam int HalfRomBase = 104670;
    localparam logic [ByteW-1:0] LeadFirstLo  = 8'h81;
    localparam logic [ByteW-1:0] LeadFirstHi  = 8'h9f;
    localparam logic [ByteW-1:0] LeadSecondLo = 8'he0;
    localparam logic [ByteW-1:0] GlyphFirst   = 8'h21;
    localparam logic [ApbAddrW-1:0] FontLoadedAddr = ApbAddrW'(4 * RegFontLoaded);

    // double-byte code ranges of the glyph rom, in rom order
    localparam logic [0:RangeN-1][15:0] CodeLo = {
        16'h8140, 16'h8180, 16'h81b8, 16'h81c8, 16'h81da, 16'h81f0, 16'h81fc, 16'h824f,
        16'h8260, 16'h8281, 16'h829f, 16'h8340, 16'h8380, 16'h839f, 16'h83bf, 16'h8440,
        16'h8470, 16'h8480, 16'h849f, 16'h889f, 16'h8940, 16'h8980, 16'h8a40, 16'h8a80,
        16'h8b40, 16'h8b80, 16'h8c40, 16'h8c80, 16'h8d40, 16'h8d80, 16'h8e40, 16'h8e80,
        16'h8f40, 16'h8f80, 16'h9040, 16'h9080, 16'h9140, 16'h9180, 16'h9240, 16'h9280,
        16'h9340, 16'h9380, 16'h9440, 16'h9480, 16'h9540, 16'h9580, 16'h9640, 16'h9680,
        16'h9740, 16'h9780, 16'h9840
    };
    localparam logic [0:RangeN-1][15:0] CodeHi = {
        16'h817e, 16'h81ac, 16'h81bf, 16'h81ce, 16'h81e8, 16'h81f7, 16'h81fc, 16'h8258,
        16'h8279, 16'h829a, 16'h82f1, 16'h837e, 16'h8396, 16'h83b6, 16'h83d6, 16'h8460,
        16'h847e, 16'h8491, 16'h84be, 16'h88fc, 16'h897e, 16'h89fc, 16'h8a7e, 16'h8afc,
        16'h8b7e, 16'h8bfc, 16'h8c7e, 16'h8cfc, 16'h8d7e, 16'h8dfc, 16'h8e7e, 16'h8efc,
        16'h8f7e, 16'h8ffc, 16'h907e, 16'h90fc, 16'h917e, 16'h91fc, 16'h927e, 16'h92fc,
        16'h937e, 16'h93fc, 16'h947e, 16'h94fc, 16'h957e, 16'h95fc, 16'h967e, 16'h96fc,
        16'h977e, 16'h97fc, 16'h9872
    };

    typedef struct packed {
        t_kind             kind;
        logic [AddrW-1:0]  addr;
        logic [PenW-1:0]   x;
    } t_glyph_result;

    t_glyph_result    glyph_q [$];
    logic             font_on;
    logic             lead_held;
    logic [ByteW-1:0] lead_val;
    logic [PenW-1:0]  pen;

    function automatic logic [PenW-1:0] pen_after(input logic [PenW-1:0] pos, input int step);
        int nxt;
        nxt = int'(pos) + step;
        return (nxt > PenTop) ? PenW'(PenTop) : PenW'(nxt);
    endfunction

    // glyph offset of a double-byte code, hit low when no range holds it
    function automatic logic code_lookup(input logic [15:0] code,
                                         output logic [AddrW-1:0] addr);
        int unsigned seen;
        seen = 0;
        addr = '0;
        for (int r = 0; r < RangeN; r++) begin
            if (code >= CodeLo[r] && code <= CodeHi[r]) begin
                addr = AddrW'((seen + code - CodeLo[r]) * FullStep);
                return 1'b1;
            end
            seen += CodeHi[r] - CodeLo[r] + 1;
        end
        return 1'b0;
    endfunction

    always @(posedge i_clk) begin : scoreboard
        t_glyph_result    want;
        logic             emit;
        logic             hit;
        logic [AddrW-1:0] full_addr;
        if (!i_rst_n) begin
            glyph_q.delete();
            font_on      = 1'b0;
            lead_held    = 1'b0;
            lead_val     = '0;
            pen          = '0;
            o_mismatches = 0;
        end else begin
            // result side first: it always belongs to an older transaction
            if (i_out_valid && i_out_ready) begin
                if (glyph_q.size() == 0) begin
                    $error("unexpected result: kind %0d font_address %0d char_x %0d",
                           i_result_kind, i_font_address, i_char_x);
                    o_mismatches++;
                end else begin
                    want = glyph_q.pop_front();
                    if (i_result_kind !== want.kind) begin
                        $error("result_kind mismatch: expected %0d, actual %0d",
                               want.kind, i_result_kind);
                        o_mismatches++;
                    end
                    if (i_font_address !== want.addr) begin
                        $error("font_address mismatch: expected %0d, actual %0d",
                               want.addr, i_font_address);
                        o_mismatches++;
                    end
                    if (i_char_x !== want.x) begin
                        $error("char_x mismatch: expected %0d, actual %0d",
                               want.x, i_char_x);
                        o_mismatches++;
                    end
                end
            end

            if (i_in_valid && i_in_ready) begin
                if (i_string_start) begin
                    pen       = i_start_x;
                    lead_held = 1'b0;
                    lead_val  = '0;
                end
                emit      = 1'b1;
                want.kind = KIND_NONE;
                want.addr = '0;
                want.x    = pen;
                if (i_text_byte == '0) begin
                    // end of string drops a pending lead, pen stays
                    lead_held = 1'b0;
                    lead_val  = '0;
                    want.kind = KIND_END;
                end else if (lead_held) begin
                    hit       = code_lookup({lead_val, i_text_byte}, full_addr);
                    lead_held = 1'b0;
                    lead_val  = '0;
                    if (hit && font_on) begin
                        want.kind = KIND_FULL;
                        want.addr = full_addr;
                    end
                    pen = pen_after(pen, 2 * CharW);
                end else if ((i_text_byte >= LeadFirstLo && i_text_byte <= LeadFirstHi)
                             || i_text_byte >= LeadSecondLo) begin
                    lead_held = 1'b1;
                    lead_val  = i_text_byte;
                    emit      = 1'b0;
                end else begin
                    if (i_render_half && font_on && i_text_byte >= GlyphFirst) begin
                        want.kind = KIND_HALF;
                        want.addr = AddrW'(HalfRomBase
                                    + (int'(i_text_byte) - int'(GlyphFirst)) * HalfStep);
                    end
                    pen = pen_after(pen, CharW);
                end
                if (emit) begin
                    glyph_q.push_back(want);
                end
            end

            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr == FontLoadedAddr) begin
                font_on = i_pwdata[0];
            end
        end
        o_pending = glyph_q.size();
    end

endmodule

// ===== tb/sjis_text_to_glyph_address_tb.sv =====
// testbench top: text stimulus, result backpressure, register writes and the verdict
`timescale 1ns / 1ps

module sjis_text_to_glyph_address_tb;

    import sjis_pkg::*;

    localparam int CharW        = 8;
    localparam int HalfPeriod   = 6;
    localparam int ResetCycles  = 5;
    localparam int SettleCycles = 6;      // two pipeline stages plus margin
    localparam int HoldCycles   = 300;    // long result-side hold-off
    localparam int StallLimit   = 3000;   // cycles with no transaction at all
    localparam int PhaseItems   = 260;
    localparam logic [0:4] PhaseFont = 5'b10101;
    localparam logic [ApbAddrW-1:0] FontLoadedAddr = ApbAddrW'(4 * RegFontLoaded);

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_ready;
    logic [ByteW-1:0]    i_text_byte;
    logic                i_string_start;
    logic [PenW-1:0]     i_start_x;
    logic                i_render_half;
    logic                o_out_valid;
    logic                i_out_ready;
    logic [1:0]          o_result_kind;
    logic [AddrW-1:0]    o_font_address;
    logic [PenW-1:0]     o_char_x;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ApbAddrW-1:0] paddr;
    logic [ApbDataW-1:0] pwdata;
    logic [ApbDataW-1:0] prdata;
    logic                pready;

    int mismatch_total;
    int glyphs_outstanding;
    int items_sent = 0;
    int quiet_cycles = 0;

    // knobs shared between the text feeder and the result sink
    int   hold_requests = 0;     // each new request makes the sink hold ready low once
    logic sink_free    = 1'b0;   // sink always ready
    logic feed_busy    = 1'b0;   // feeder inserts no gaps

    // state of the string being built by the random generator
    logic            str_start;
    logic [PenW-1:0] str_x;

    sjis_text_to_glyph_address #(
        .CHAR_WIDTH(CharW)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_text_byte    (i_text_byte),
        .i_string_start (i_string_start),
        .i_start_x      (i_start_x),
        .i_render_half  (i_render_half),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_result_kind  (o_result_kind),
        .o_font_address (o_font_address),
        .o_char_x       (o_char_x),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    // prediction and comparison live beside the block, fed from the same wires
    sjis_glyph_checker #(
        .CharW(CharW)
    ) u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_ready     (o_in_ready),
        .i_text_byte    (i_text_byte),
        .i_string_start (i_string_start),
        .i_start_x      (i_start_x),
        .i_render_half  (i_render_half),
        .i_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .i_result_kind  (o_result_kind),
        .i_font_address (o_font_address),
        .i_char_x       (o_char_x),
        .i_psel         (psel),
        .i_penable      (penable),
        .i_pwrite       (pwrite),
        .i_pready       (pready),
        .i_paddr        (paddr),
        .i_pwdata       (pwdata),
        .o_mismatches   (mismatch_total),
        .o_pending      (glyphs_outstanding)
    );

    always begin
        #(HalfPeriod) i_clk = 1'b1;
        #(HalfPeriod) i_clk = 1'b0;
    end

    // watchdog: any transaction on text, result or register port restarts the count
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (psel && penable && pready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == StallLimit) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(25, 60);
    endfunction

    function automatic logic half_on();
        return $urandom_range(0, 7) != 0;
    endfunction

    // result sink: alternating ready runs and stalls, or always ready, a long hold-off on request
    initial begin : result_sink
        int   run;
        int   holds_done;
        logic level;
        i_out_ready = 1'b0;
        run        = 0;
        holds_done = 0;
        level      = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_requests != holds_done) begin
                i_out_ready <= 1'b0;
                repeat (HoldCycles - 1) @(negedge i_clk);
                holds_done++;
                run = 0;
            end else if (sink_free) begin
                i_out_ready <= 1'b1;
            end else begin
                if (run == 0) begin
                    level = !level;
                    run   = level ? $urandom_range(1, 16) : gap_len() + 1;
                end
                i_out_ready <= level;
                run--;
            end
        end
    end

    // drop valid and let the text side rest; n sets the length of the rest, zero skips it
    task automatic pause_input(input int n);
        if (n > 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (n - 1) @(negedge i_clk);
        end
    endtask

    // one text transaction; valid holds with a steady payload until accepted
    task automatic feed(input logic [ByteW-1:0] c, input logic st,
                        input logic [PenW-1:0] sx, input logic draw);
        @(negedge i_clk);
        i_in_valid     <= 1'b1;
        i_text_byte    <= c;
        i_string_start <= st;
        i_start_x      <= sx;
        i_render_half  <= draw;
        do @(posedge i_clk); while (!o_in_ready);
        items_sent++;
        if (!feed_busy) begin
            pause_input(gap_len());
        end
    endtask

    // next byte of the current random string; start position only on its first byte
    task automatic feed_char(input logic [ByteW-1:0] c);
        feed(c, str_start, str_start ? str_x : PenW'($urandom), half_on());
        str_start = 1'b0;
    endtask

    // sender pause: nothing new until every expected result has come out
    task automatic wait_results_done();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (glyphs_outstanding != 0);
        // a trailing lead byte gives no result but may still be in the pipe
        repeat (SettleCycles) @(negedge i_clk);
    endtask

    // register write on an idle block: setup cycle, then access cycle
    task automatic write_font_loaded(input logic on);
        wait_results_done();
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= FontLoadedAddr;
        pwdata  <= ApbDataW'(on);
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // well-formed string with random content, sometimes broken by a dangling lead
    task automatic send_string();
        int n;
        int r;
        logic [ByteW-1:0] lead;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
        str_start = ($urandom_range(0, 9) != 0);
        str_x = ($urandom_range(0, 4) == 0) ? PenW'($urandom_range(3900, 4095))
                                            : PenW'($urandom_range(0, 4095));
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            if ($urandom_range(0, 7) == 0) begin
                // any lead, most of these miss the rom ranges
                lead = $urandom_range(0, 1) ? ByteW'($urandom_range(8'h81, 8'h9f))
                                            : ByteW'($urandom_range(8'he0, 8'hff));
            end else begin
                lead = ByteW'($urandom_range(8'h81, 8'h98));
            end
            if (r < 45) begin
                feed_char(lead);
                feed_char(($urandom_range(0, 9) == 0) ? ByteW'($urandom_range(1, 255))
                                                      : ByteW'($urandom_range(8'h40, 8'hfc)));
            end else if (r < 85) begin
                feed_char($urandom_range(0, 3) == 0 ? ByteW'($urandom_range(8'ha1, 8'hdf))
                                                    : ByteW'($urandom_range(8'h21, 8'h7e)));
            end else if (r < 95) begin
                // space, control bytes and the odd single bytes around the lead ranges
                case ($urandom_range(0, 3))
                    0: feed_char(8'h20);
                    1: feed_char(8'h80);
                    2: feed_char(8'ha0);
                    default: feed_char(ByteW'($urandom_range(1, 8'h1f)));
                endcase
            end else begin
                // dangling lead: the end byte drops it, or the string stops here with the lead pending
                feed_char(lead);
                if ($urandom_range(0, 1)) return;
                break;
            end
        end
        feed_char(8'h00);
    endtask

    task automatic send_noise();
        int n;
        n = $urandom_range(1, 6);
        repeat (n) begin
            feed(ByteW'($urandom), $urandom_range(0, 9) == 0, PenW'($urandom), half_on());
        end
    endtask

    task automatic random_text(input int upto);
        while (items_sent < upto) begin
            if ($urandom_range(0, 99) < 85) begin
                send_string();
            end else begin
                send_noise();
            end
        end
    endtask

    initial begin : stimulus
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_text_byte    = '0;
        i_string_start = 1'b0;
        i_start_x      = '0;
        i_render_half  = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        str_start      = 1'b0;
        str_x          = '0;
        repeat (ResetCycles) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed text with the font present
        write_font_loaded(1'b1);
        feed(8'h41, 1'b1, 12'h000, 1'b1);     // plain ascii glyph from pen zero
        feed(8'h21, 1'b0, 12'hfff, 1'b1);     // first half-width glyph
        feed(8'hdf, 1'b0, 12'h000, 1'b1);     // last half-width katakana
        feed(8'ha0, 1'b0, 12'h000, 1'b1);     // single byte between the lead ranges
        feed(8'h20, 1'b0, 12'h000, 1'b1);     // space: no glyph, pen moves
        feed(8'h01, 1'b0, 12'h000, 1'b1);     // control byte below the glyph set
        feed(8'h41, 1'b0, 12'h000, 1'b0);     // half-width drawing off
        feed(8'h81, 1'b0, 12'h000, 1'b0);     // first code of the first range
        feed(8'h40, 1'b0, 12'h000, 1'b0);
        feed(8'h98, 1'b0, 12'h000, 1'b1);     // last code of the last range
        feed(8'h72, 1'b0, 12'h000, 1'b1);
        feed(8'h81, 1'b0, 12'h000, 1'b1);     // hole between two ranges
        feed(8'h7f, 1'b0, 12'h000, 1'b1);
        feed(8'hff, 1'b0, 12'h000, 1'b1);     // highest lead and trail
        feed(8'hff, 1'b0, 12'h000, 1'b1);
        feed(8'he0, 1'b0, 12'h000, 1'b1);     // trail byte taken from the lead range
        feed(8'h9f, 1'b0, 12'h000, 1'b1);
        feed(8'h81, 1'b0, 12'h000, 1'b1);     // end of string drops the pending lead
        feed(8'h00, 1'b0, 12'h000, 1'b1);
        feed(8'h00, 1'b0, 12'h000, 1'b1);     // bytes after the end keep the pen
        feed(8'h88, 1'b0, 12'h000, 1'b1);     // lead cleared by a new string start
        feed(8'h41, 1'b1, 12'd4090, 1'b1);    // pen saturates at the right edge
        feed(8'h82, 1'b0, 12'h000, 1'b1);     // full-width at a saturated pen
        feed(8'ha0, 1'b0, 12'h000, 1'b1);
        feed(8'h00, 1'b0, 12'h000, 1'b1);

        // no font: nothing draws, the pen still moves
        write_font_loaded(1'b0);
        feed(8'h41, 1'b1, 12'hfff, 1'b1);
        feed(8'h81, 1'b0, 12'h000, 1'b1);
        feed(8'h40, 1'b0, 12'h000, 1'b1);
        feed(8'h00, 1'b0, 12'h000, 1'b1);

        // random phases, the font register toggled at every boundary
        for (int p = 0; p < 5; p++) begin
            write_font_loaded(PhaseFont[p]);
            if (p == 1) begin
                // stretch with no idling on either side
                sink_free = 1'b1;
                feed_busy = 1'b1;
                random_text(items_sent + 150);
                sink_free = 1'b0;
                feed_busy = 1'b0;
            end
            if (p == 2) begin
                // long result hold-off while bytes keep coming: the pipe fills and stalls
                random_text(items_sent + 100);
                hold_requests++;
                feed_busy    = 1'b1;
                random_text(items_sent + 40);
                feed_busy    = 1'b0;
                wait_results_done();
            end
            random_text(items_sent + PhaseItems);
        end

        wait_results_done();
        if (mismatch_total == 0 && glyphs_outstanding == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
